FILE: design/wam_pkg.sv
package wam_pkg;

   localparam int WINDOW         = 64;
   localparam int SAMPLE_W       = 32;
   localparam int SAMPLE_COUNT_W = 7;
   localparam int POS_W          = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W          = $clog2(WINDOW + 1);
   localparam int SUM_W          = SAMPLE_W + $clog2(WINDOW);
   localparam int DIV_CNT_W      = $clog2(SUM_W + 1);

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_CLEAR  = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

endpackage

FILE: design/wam_ram.sv
module wam_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/wam_div.sv
module wam_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [wam_pkg::SUM_W-1:0]  dividend,
   input  logic [wam_pkg::CNT_W-1:0]  divisor,
   output logic                       done,
   output logic [wam_pkg::SUM_W-1:0]  quotient
);

   import wam_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     divisor_ff, divisor_in;
   logic [CNT_W:0]       shifted;
   logic                 fits;

   // restoring division, one quotient bit per cycle, MSB first
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = DIV_CNT_W'(SUM_W);
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? CNT_W'(shifted - {1'b0, divisor_ff}) : CNT_W'(shifted);
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/window_average_min_max.sv
// Moving-average statistics over elapsed-time samples. Each request either
// records a sample or clears all statistics, and returns one response with the
// truncated window average, the min and max since the last clear, and the
// number of samples held (saturating at the window size). The last WINDOW
// samples live in a one-port-read/one-port-write RAM; when the window is full
// the oldest entry is read back and removed from the running sum. A sample
// request steps through ST_UPDATE, ST_DIV_START, ST_DIV_WAIT and ST_OUT, and
// stays in ST_DIV_WAIT while the bit-serial divider forms the average; its
// response is registered as the block leaves ST_OUT, which waits until the
// response register is free. A clear goes straight from ST_IDLE to ST_OUT.
// A new request is taken while the previous response still waits on rsp_ready.
// The sample RAM needs no clearing after reset.
module window_average_min_max (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [wam_pkg::SAMPLE_W-1:0]         req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [wam_pkg::SAMPLE_W-1:0]         rsp_average,
   output logic [wam_pkg::SAMPLE_W-1:0]         rsp_min_seen,
   output logic [wam_pkg::SAMPLE_W-1:0]         rsp_max_seen,
   output logic [wam_pkg::SAMPLE_COUNT_W-1:0]   rsp_sample_count
);

   import wam_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] largest_ff, largest_in;
   logic [SAMPLE_W-1:0] smallest_ff, smallest_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]       rsp_average_ff, rsp_average_in;
   logic [SAMPLE_W-1:0]       rsp_min_ff, rsp_min_in;
   logic [SAMPLE_W-1:0]       rsp_max_ff, rsp_max_in;
   logic [SAMPLE_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                accept;
   logic                do_clear;
   logic                do_update;
   logic                div_start;
   logic                out_load;
   logic                out_free;
   logic                full;
   logic [SAMPLE_W-1:0] ring_rd_data;
   logic                div_done;
   logic [SUM_W-1:0]    div_quotient;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign full     = count_ff >= FULL_CNT;

   wam_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (do_update),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (ring_rd_data)
   );

   wam_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_kind == REQ_CLEAR) ? ST_OUT : ST_UPDATE;
            end
         end
         ST_UPDATE:    state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      do_update = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_ready = 1'b1;
         ST_UPDATE:    do_update = 1'b1;
         ST_DIV_START: div_start = 1'b1;
         ST_DIV_WAIT:  ;
         ST_OUT:       out_load  = out_free;
         default:      ;
      endcase
   end

   assign do_clear = accept && (req_kind == REQ_CLEAR);

   // statistics update; RAM read data is the oldest sample in ST_UPDATE
   always_comb begin
      sample_in   = accept ? req_sample : sample_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      largest_in  = largest_ff;
      smallest_in = smallest_ff;
      if (do_clear) begin
         pos_in      = '0;
         count_in    = '0;
         sum_in      = '0;
         largest_in  = '0;
         smallest_in = '1;
      end else if (do_update) begin
         sum_in = sum_ff - (full ? SUM_W'(ring_rd_data) : '0) + SUM_W'(sample_ff);
         if (sample_ff > largest_ff) begin
            largest_in = sample_ff;
         end
         if (sample_ff < smallest_ff) begin
            smallest_in = sample_ff;
         end
         pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
         if (!full) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in   = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_average_in = rsp_average_ff;
      rsp_min_in     = rsp_min_ff;
      rsp_max_in     = rsp_max_ff;
      rsp_count_in   = rsp_count_ff;
      if (out_load) begin
         rsp_average_in = (count_ff == '0) ? '0 : SAMPLE_W'(div_quotient);
         rsp_min_in     = smallest_ff;
         rsp_max_in     = largest_ff;
         rsp_count_in   = SAMPLE_COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         largest_ff   <= '0;
         smallest_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         largest_ff   <= largest_in;
         smallest_ff  <= smallest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff      <= sample_in;
      rsp_average_ff <= rsp_average_in;
      rsp_min_ff     <= rsp_min_in;
      rsp_max_ff     <= rsp_max_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_average      = rsp_average_ff;
   assign rsp_min_seen     = rsp_min_ff;
   assign rsp_max_seen     = rsp_max_ff;
   assign rsp_sample_count = rsp_count_ff;

endmodule

FILE: bench/window_average_min_max_tb.sv
module window_average_min_max_tb;
   import wam_pkg::*;

   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam int PRINT_LIMIT  = 40;

   typedef enum int {
      VALUES_ANY,
      VALUES_SMALL,
      VALUES_EXTREME,
      VALUES_NEAR_EDGE
   } value_flavor_type;

   typedef enum int {
      RSP_ALWAYS,
      RSP_MOSTLY,
      RSP_RARELY,
      RSP_PERIODIC
   } stall_mode_type;

   typedef struct packed {
      req_kind_type          kind;
      logic [SAMPLE_W-1:0]   sample;
   } request_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]         average;
      logic [SAMPLE_W-1:0]         min_seen;
      logic [SAMPLE_W-1:0]         max_seen;
      logic [SAMPLE_COUNT_W-1:0]   sample_count;
   } stats_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_kind = 1'b0;
   logic [SAMPLE_W-1:0]         req_sample = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0]         rsp_average;
   logic [SAMPLE_W-1:0]         rsp_min_seen;
   logic [SAMPLE_W-1:0]         rsp_max_seen;
   logic [SAMPLE_COUNT_W-1:0]   rsp_sample_count;

   window_average_min_max uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .rsp_min_seen     (rsp_min_seen),
      .rsp_max_seen     (rsp_max_seen),
      .rsp_sample_count (rsp_sample_count)
   );

   request_type pending[$];
   stats_type   expected_stats[$];
   int          sent_count  = 0;
   int          error_count = 0;
   int          cycle_count = 0;

   // mirror of the block's statistics
   logic [SAMPLE_W-1:0] ring_mirror [WINDOW];
   logic [POS_W-1:0]    slot        = '0;
   logic [CNT_W-1:0]    held        = '0;
   logic [SUM_W-1:0]    running_sum = '0;
   logic [SAMPLE_W-1:0] low_mark    = '1;
   logic [SAMPLE_W-1:0] high_mark   = '0;

   function automatic stats_type update_stats(request_type r);
      stats_type           s;
      logic [SUM_W-1:0]    quotient;
      if (r.kind == REQ_CLEAR) begin
         slot        = '0;
         held        = '0;
         running_sum = '0;
         high_mark   = '0;
         low_mark    = '1;
      end else begin
         // full window: the slot about to be overwritten holds the oldest sample
         if (held == WINDOW)
            running_sum = running_sum - ring_mirror[slot];
         ring_mirror[slot] = r.sample;
         running_sum = running_sum + r.sample;
         if (r.sample > high_mark)
            high_mark = r.sample;
         if (r.sample < low_mark)
            low_mark = r.sample;
         slot = (slot == WINDOW - 1) ? '0 : slot + 1'b1;
         if (held < WINDOW)
            held = held + 1'b1;
      end
      quotient       = (held == 0) ? '0 : running_sum / held;
      s.average      = quotient[SAMPLE_W-1:0];
      s.min_seen     = low_mark;
      s.max_seen     = high_mark;
      s.sample_count = SAMPLE_COUNT_W'(held);
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (error_count < PRINT_LIMIT)
         $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   task automatic queue_request(req_kind_type kind, logic [SAMPLE_W-1:0] sample);
      pending.push_back('{kind, sample});
   endtask

   function automatic logic [SAMPLE_W-1:0] draw_sample(value_flavor_type flavor);
      logic [SAMPLE_W-1:0] v;
      case (flavor)
         VALUES_SMALL: v = $urandom_range(0, 1000);
         VALUES_EXTREME: begin
            case ($urandom_range(0, 3))
               0: v = '0;
               1: v = '1;
               2: v = 32'h1;
               default: v = 32'hFFFF_FFFE;
            endcase
         end
         VALUES_NEAR_EDGE:
            v = ($urandom_range(0, 1) ? 32'hFFFF_FF00 : 32'h0) | $urandom_range(0, 255);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // driver: bursts of requests separated by random gaps
   int          burst_left = 1;
   int          gap_left   = 0;
   logic        accepted;
   request_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         accepted = req_valid && req_ready;
         if (accepted) begin
            expected_stats.push_back(update_stats('{req_kind_type'(req_kind), req_sample}));
            sent_count++;
         end
         if (!req_valid || accepted) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending.size() > 0) begin
               next_req = pending.pop_front();
               req_valid  <= 1'b1;
               req_kind   <= next_req.kind;
               req_sample <= next_req.sample;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks responses and stalls the response channel
   stats_type      got;
   stats_type      want;
   stall_mode_type stall_mode  = RSP_ALWAYS;
   int             stall_left  = 0;
   int             stall_tick  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_average, rsp_min_seen, rsp_max_seen, rsp_sample_count};
            if (expected_stats.size() == 0) begin
               report_mismatch("unexpected response, average", got.average, 0);
            end else begin
               want = expected_stats.pop_front();
               if (got.average !== want.average)
                  report_mismatch("average", got.average, want.average);
               if (got.min_seen !== want.min_seen)
                  report_mismatch("min_seen", got.min_seen, want.min_seen);
               if (got.max_seen !== want.max_seen)
                  report_mismatch("max_seen", got.max_seen, want.max_seen);
               if (got.sample_count !== want.sample_count)
                  report_mismatch("sample_count", got.sample_count, want.sample_count);
            end
         end
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = $urandom_range(50, 400);
         end else begin
            stall_left--;
         end
         stall_tick++;
         case (stall_mode)
            RSP_ALWAYS:   rsp_ready <= 1'b1;
            RSP_MOSTLY:   rsp_ready <= ($urandom_range(0, 3) != 0);
            RSP_RARELY:   rsp_ready <= ($urandom_range(0, 3) == 0);
            default:      rsp_ready <= ((stall_tick % 23) < 4);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int               total;
      int               made;
      int               run_len;
      value_flavor_type flavor;

      // directed: empty window, field extremes, truncation, repeated clears
      queue_request(REQ_CLEAR, 32'h0);
      queue_request(REQ_SAMPLE, 32'h0);
      queue_request(REQ_SAMPLE, 32'hFFFF_FFFF);
      queue_request(REQ_SAMPLE, 32'h1);
      queue_request(REQ_SAMPLE, 32'h8000_0000);
      queue_request(REQ_SAMPLE, 32'h7FFF_FFFF);
      queue_request(REQ_CLEAR, 32'hFFFF_FFFF);
      queue_request(REQ_SAMPLE, 32'd5);
      queue_request(REQ_SAMPLE, 32'd10);
      queue_request(REQ_SAMPLE, 32'd4);
      queue_request(REQ_CLEAR, 32'h5555_5555);
      queue_request(REQ_CLEAR, 32'hAAAA_AAAA);
      queue_request(REQ_SAMPLE, 32'h5555_5555);
      queue_request(REQ_SAMPLE, 32'hAAAA_AAAA);
      queue_request(REQ_SAMPLE, 32'hFFFF_FFFF);
      queue_request(REQ_SAMPLE, 32'hFFFF_FFFF);
      queue_request(REQ_CLEAR, 32'h0);
      queue_request(REQ_SAMPLE, 32'hFFFF_FFFF);
      queue_request(REQ_CLEAR, 32'h0);

      // random: runs of samples, many long enough to wrap the window,
      // broken up by clears
      made = 0;
      while (made < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_request(REQ_CLEAR, $urandom);
            made++;
         end else begin
            flavor  = value_flavor_type'($urandom_range(0, 3));
            run_len = $urandom_range(0, 1) ? $urandom_range(WINDOW + 1, 3 * WINDOW)
                                           : $urandom_range(1, WINDOW);
            if (run_len > RANDOM_ITEMS - made)
               run_len = RANDOM_ITEMS - made;
            repeat (run_len) begin
               // mix in other value kinds now and then
               if ($urandom_range(0, 7) == 0)
                  queue_request(REQ_SAMPLE,
                                draw_sample(value_flavor_type'($urandom_range(0, 3))));
               else
                  queue_request(REQ_SAMPLE, draw_sample(flavor));
            end
            made += run_len;
            if ($urandom_range(0, 2) == 0) begin
               queue_request(REQ_CLEAR, $urandom);
               made++;
            end
         end
      end
      total = pending.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (sent_count < total)
         @(negedge clock);
      while (expected_stats.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: window_average_min_max.f
design/wam_pkg.sv
design/wam_ram.sv
design/wam_div.sv
design/window_average_min_max.sv
bench/window_average_min_max_tb.sv
